// ===== src/stepped_sphere_sweep_vs_box_defines.svh =====
// Assertion macros for the stepped sphere sweep block.
// Included by the files that carry concurrent checks; no other dependencies.
`ifndef STEPPED_SPHERE_SWEEP_VS_BOX_DEFINES_SVH
`define STEPPED_SPHERE_SWEEP_VS_BOX_DEFINES_SVH

// same-cycle implication, disabled while in reset
`define SSVB_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("ssvb check failed");

// next-cycle implication, disabled while in reset
`define SSVB_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("ssvb check failed");

`endif

// ===== src/ssvb_pkg.sv =====
// Shared widths, register codes and state types for the stepped sphere sweep.
// No dependencies; compiled first.
package ssvb_pkg;

    localparam int NUM_AXES   = 3;
    localparam int AXIS_W     = 2;
    localparam int COORD_IN_W = 32;             // port coordinate width
    localparam int HALF_W     = 31;             // box half extent width
    localparam int RADIUS_W   = 31;
    localparam int STEP_W     = 7;              // step_count register width
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 31;
    localparam int MAG_W      = 32;             // |end - start| fits here
    localparam int QUO_W      = MAG_W + 1;      // signed substep
    localparam int BOUND_W    = 34;             // box bounds and trial sums
    localparam int DIST_W     = BOUND_W + 1;    // signed distance to the box
    localparam int SQ_W       = 2 * RADIUS_W;
    localparam int SUM_W      = 64;

    localparam logic [AXIS_W-1:0] AXIS_LAST = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_COUNT    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_SPHERE_RADIUS = 1'b1;

    localparam logic [STEP_W-1:0]   STEP_COUNT_RESET = 7'd8;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET     = 31'd65536;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_RSQ,
        ST_TRIAL,
        ST_DIST,
        ST_SQUARE,
        ST_UPDATE,
        ST_DONE
    } sweep_state_t;

    typedef enum logic [1:0] {
        DIV_IDLE,
        DIV_RUN,
        DIV_SIGN,
        DIV_DONE
    } div_state_t;

endpackage

// ===== src/ssvb_if.sv =====
// Query and result channel interfaces (valid/ready plus payload).
// Depends on ssvb_pkg.
interface ssvb_query_if;
    import ssvb_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_IN_W-1:0] start_x;
    logic signed [COORD_IN_W-1:0] start_y;
    logic signed [COORD_IN_W-1:0] start_z;
    logic signed [COORD_IN_W-1:0] end_x;
    logic signed [COORD_IN_W-1:0] end_y;
    logic signed [COORD_IN_W-1:0] end_z;
    logic signed [COORD_IN_W-1:0] box_center_x;
    logic signed [COORD_IN_W-1:0] box_center_y;
    logic signed [COORD_IN_W-1:0] box_center_z;
    logic        [HALF_W-1:0]     box_half_x;
    logic        [HALF_W-1:0]     box_half_y;
    logic        [HALF_W-1:0]     box_half_z;

    modport source (
        output valid, start_x, start_y, start_z, end_x, end_y, end_z,
               box_center_x, box_center_y, box_center_z,
               box_half_x, box_half_y, box_half_z,
        input  ready
    );

    modport sink (
        input  valid, start_x, start_y, start_z, end_x, end_y, end_z,
               box_center_x, box_center_y, box_center_z,
               box_half_x, box_half_y, box_half_z,
        output ready
    );
endinterface

interface ssvb_result_if;
    import ssvb_pkg::*;

    logic                         valid;
    logic                         ready;
    logic signed [COORD_IN_W-1:0] final_x;
    logic signed [COORD_IN_W-1:0] final_y;
    logic signed [COORD_IN_W-1:0] final_z;

    modport source (output valid, final_x, final_y, final_z, input ready);
    modport sink (input valid, final_x, final_y, final_z, output ready);
endinterface

// ===== src/stepped_sphere_sweep_vs_box.sv =====
// Stepped sphere sweep against an axis-aligned box, one query at a time.
// From accept to result: three serial divisions, one radius square, then one axis
// test per axis and step (steps = clamped step_count) through the single
// trial/distance/square/compare unit, start pass included. A new query is accepted
// only after the result has been taken. Async active-low reset clears control state
// and loads step_count = 8, sphere_radius = 1.0.
`include "stepped_sphere_sweep_vs_box_defines.svh"

module stepped_sphere_sweep_vs_box #(
    parameter int MAX_STEPS   = 64,
    parameter int COORD_WIDTH = 32
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    ssvb_query_if.sink                           query,
    ssvb_result_if.source                        result,
    input  logic                                 cfg_we,
    input  logic [ssvb_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [ssvb_pkg::CFG_DATA_W-1:0]      cfg_data
);
    import ssvb_pkg::*;

    localparam logic signed [BOUND_W-1:0] CMAX =
        BOUND_W'((64'sd1 <<< (COORD_WIDTH - 1)) - 64'sd1);
    localparam logic signed [BOUND_W-1:0] CMIN = -CMAX - BOUND_W'(1);

    // control
    sweep_state_t             state_reg, state_next;
    logic [AXIS_W-1:0]        axis_reg, axis_next;
    logic [STEP_W-1:0]        step_reg, step_next;
    logic                     init_reg, init_next;
    logic [STEP_W-1:0]        step_count_reg;
    logic [RADIUS_W-1:0]      radius_reg;

    // datapath
    logic signed [COORD_WIDTH-1:0] cur_reg [NUM_AXES];
    logic signed [COORD_WIDTH-1:0] cur_next [NUM_AXES];
    logic signed [COORD_IN_W-1:0]  end_reg [NUM_AXES];
    logic signed [COORD_IN_W-1:0]  end_next [NUM_AXES];
    logic signed [QUO_W-1:0]       mv_reg [NUM_AXES];
    logic signed [QUO_W-1:0]       mv_next [NUM_AXES];
    logic signed [BOUND_W-1:0]     lo_reg [NUM_AXES];
    logic signed [BOUND_W-1:0]     lo_next [NUM_AXES];
    logic signed [BOUND_W-1:0]     hi_reg [NUM_AXES];
    logic signed [BOUND_W-1:0]     hi_next [NUM_AXES];
    logic [SQ_W-1:0]               sq_reg [NUM_AXES];
    logic [SQ_W-1:0]               sq_next [NUM_AXES];
    logic [NUM_AXES-1:0]           far_reg, far_next;
    logic signed [COORD_WIDTH-1:0] trial_reg, trial_next;
    logic [RADIUS_W-1:0]           m_reg, m_next;
    logic                          far_new_reg, far_new_next;
    logic [SQ_W-1:0]               sq_new_reg, sq_new_next;
    logic [SQ_W-1:0]               rsq_reg, rsq_next;

    // port views as axis arrays
    logic signed [COORD_IN_W-1:0] start_in [NUM_AXES];
    logic signed [COORD_IN_W-1:0] end_in [NUM_AXES];
    logic signed [COORD_IN_W-1:0] ctr_in [NUM_AXES];
    logic        [HALF_W-1:0]     half_in [NUM_AXES];

    logic [STEP_W-1:0]          steps_eff;
    logic                       last_step;
    logic                       div_start;
    logic                       div_done;
    logic signed [QUO_W-1:0]    div_quot;
    logic signed [QUO_W-1:0]    div_dividend;
    logic [RADIUS_W-1:0]        mul_op;
    logic [SQ_W-1:0]            prod;
    logic signed [BOUND_W-1:0]  trial_sum;
    logic signed [DIST_W-1:0]   below;
    logic signed [DIST_W-1:0]   above;
    logic [DIST_W-1:0]          box_gap;
    logic [NUM_AXES-1:0]        far_view;
    logic [SUM_W-1:0]           sq_sum;
    logic                       touch;

    assign start_in[0] = query.start_x;
    assign start_in[1] = query.start_y;
    assign start_in[2] = query.start_z;
    assign end_in[0]   = query.end_x;
    assign end_in[1]   = query.end_y;
    assign end_in[2]   = query.end_z;
    assign ctr_in[0]   = query.box_center_x;
    assign ctr_in[1]   = query.box_center_y;
    assign ctr_in[2]   = query.box_center_z;
    assign half_in[0]  = query.box_half_x;
    assign half_in[1]  = query.box_half_y;
    assign half_in[2]  = query.box_half_z;

    always_comb
    begin
        if (step_count_reg == '0)
            steps_eff = STEP_W'(1);
        else if (32'(step_count_reg) > MAX_STEPS)
            steps_eff = STEP_W'(MAX_STEPS);
        else
            steps_eff = step_count_reg;
    end

    assign last_step = (step_reg == steps_eff - STEP_W'(1));

    // ---- shared unit pieces ----
    assign div_dividend = QUO_W'(end_reg[axis_reg]) - QUO_W'(cur_reg[axis_reg]);

    ssvb_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (steps_eff),
        .done     (div_done),
        .quotient (div_quot)
    );

    // one squarer: radius once per query, then the distance of each test
    assign mul_op = (state_reg == ST_RSQ) ? radius_reg : m_reg;
    assign prod   = SQ_W'(mul_op) * SQ_W'(mul_op);

    // init pass measures the start position itself
    assign trial_sum = init_reg ? BOUND_W'(cur_reg[axis_reg])
                                : BOUND_W'(cur_reg[axis_reg]) + BOUND_W'(mv_reg[axis_reg]);

    assign below = DIST_W'(lo_reg[axis_reg]) - DIST_W'(trial_reg);
    assign above = DIST_W'(trial_reg) - DIST_W'(hi_reg[axis_reg]);

    always_comb
    begin
        if (below > 0)
            box_gap = below;
        else if (above > 0)
            box_gap = above;
        else
            box_gap = '0;
    end

    always_comb
    begin
        sq_sum = '0;
        for (int b = 0; b < NUM_AXES; b++)
        begin
            if (AXIS_W'(b) == axis_reg)
            begin
                far_view[b] = far_new_reg;
                sq_sum      = sq_sum + SUM_W'(sq_new_reg);
            end
            else
            begin
                far_view[b] = far_reg[b];
                sq_sum      = sq_sum + SUM_W'(sq_reg[b]);
            end
        end
        touch = (far_view == '0) && (sq_sum <= SUM_W'(rsq_reg));
    end

    // ---- sequencer ----
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:      if (query.valid) state_next = ST_DIV_START;
            ST_DIV_START: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                    state_next = (axis_reg == AXIS_LAST) ? ST_RSQ : ST_DIV_START;
            end
            ST_RSQ:       state_next = ST_TRIAL;
            ST_TRIAL:     state_next = ST_DIST;
            ST_DIST:      state_next = ST_SQUARE;
            ST_SQUARE:    state_next = ST_UPDATE;
            ST_UPDATE:
            begin
                if (axis_reg == AXIS_LAST && !init_reg && last_step)
                    state_next = ST_DONE;
                else
                    state_next = ST_TRIAL;
            end
            ST_DONE:      if (result.ready) state_next = ST_IDLE;
            default:      state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        query.ready  = 1'b0;
        result.valid = 1'b0;
        div_start    = 1'b0;
        unique case (state_reg)
            ST_IDLE:      query.ready  = 1'b1;
            ST_DIV_START: div_start    = 1'b1;
            ST_DONE:      result.valid = 1'b1;
            default: ;
        endcase
    end

    always_comb
    begin
        axis_next    = axis_reg;
        step_next    = step_reg;
        init_next    = init_reg;
        cur_next     = cur_reg;
        end_next     = end_reg;
        mv_next      = mv_reg;
        lo_next      = lo_reg;
        hi_next      = hi_reg;
        sq_next      = sq_reg;
        far_next     = far_reg;
        trial_next   = trial_reg;
        m_next       = m_reg;
        far_new_next = far_new_reg;
        sq_new_next  = sq_new_reg;
        rsq_next     = rsq_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (query.valid)
                begin
                    for (int a = 0; a < NUM_AXES; a++)
                    begin
                        if (BOUND_W'(start_in[a]) > CMAX)
                            cur_next[a] = COORD_WIDTH'(CMAX);
                        else if (BOUND_W'(start_in[a]) < CMIN)
                            cur_next[a] = COORD_WIDTH'(CMIN);
                        else
                            cur_next[a] = COORD_WIDTH'(start_in[a]);
                        end_next[a] = end_in[a];
                        lo_next[a]  = BOUND_W'(ctr_in[a]) - BOUND_W'($signed({1'b0, half_in[a]}));
                        hi_next[a]  = BOUND_W'(ctr_in[a]) + BOUND_W'($signed({1'b0, half_in[a]}));
                    end
                    axis_next = '0;
                    step_next = '0;
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    mv_next[axis_reg] = div_quot;
                    axis_next = (axis_reg == AXIS_LAST) ? '0 : axis_reg + AXIS_W'(1);
                end
            end
            ST_RSQ:
            begin
                rsq_next  = prod;
                init_next = 1'b1;
                axis_next = '0;
                step_next = '0;
            end
            ST_TRIAL:
            begin
                if (trial_sum > CMAX)
                    trial_next = COORD_WIDTH'(CMAX);
                else if (trial_sum < CMIN)
                    trial_next = COORD_WIDTH'(CMIN);
                else
                    trial_next = COORD_WIDTH'(trial_sum);
            end
            ST_DIST:
            begin
                far_new_next = box_gap > DIST_W'(radius_reg);
                m_next       = box_gap[RADIUS_W-1:0];
            end
            ST_SQUARE:
            begin
                sq_new_next = prod;
            end
            ST_UPDATE:
            begin
                // the init pass always records, a real move only if clear of the box
                if (init_reg || !touch)
                begin
                    cur_next[axis_reg] = trial_reg;
                    sq_next[axis_reg]  = sq_new_reg;
                    far_next[axis_reg] = far_new_reg;
                end
                if (axis_reg == AXIS_LAST)
                begin
                    axis_next = '0;
                    if (init_reg)
                        init_next = 1'b0;
                    else if (!last_step)
                        step_next = step_reg + STEP_W'(1);
                end
                else
                begin
                    axis_next = axis_reg + AXIS_W'(1);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            axis_reg       <= '0;
            step_reg       <= '0;
            init_reg       <= 1'b0;
            step_count_reg <= STEP_COUNT_RESET;
            radius_reg     <= RADIUS_RESET;
        end
        else
        begin
            state_reg <= state_next;
            axis_reg  <= axis_next;
            step_reg  <= step_next;
            init_reg  <= init_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    REG_STEP_COUNT:    step_count_reg <= cfg_data[STEP_W-1:0];
                    REG_SPHERE_RADIUS: radius_reg     <= cfg_data[RADIUS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg     <= cur_next;
        end_reg     <= end_next;
        mv_reg      <= mv_next;
        lo_reg      <= lo_next;
        hi_reg      <= hi_next;
        sq_reg      <= sq_next;
        far_reg     <= far_next;
        trial_reg   <= trial_next;
        m_reg       <= m_next;
        far_new_reg <= far_new_next;
        sq_new_reg  <= sq_new_next;
        rsq_reg     <= rsq_next;
    end

    assign result.final_x = COORD_IN_W'(cur_reg[0]);
    assign result.final_y = COORD_IN_W'(cur_reg[1]);
    assign result.final_z = COORD_IN_W'(cur_reg[2]);

    `SSVB_ASSERT_IMPLY(a_one_query_in_flight, clk, rst_n, query.ready, !result.valid)
    `SSVB_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, query.valid && query.ready, !query.ready)
    `SSVB_ASSERT_IMPLY(a_step_in_range, clk, rst_n, state_reg != ST_IDLE, step_reg < steps_eff)
    `SSVB_ASSERT_IMPLY(a_axis_in_range, clk, rst_n, 1'b1, axis_reg <= AXIS_LAST)
    `SSVB_ASSERT_IMPLY(a_div_done_expected, clk, rst_n, div_done, state_reg == ST_DIV_WAIT)

endmodule

// ===== src/ssvb_div.sv =====
// Bit-serial signed divider: substep = dividend / divisor, truncated toward zero.
// One quotient bit per cycle; depends on ssvb_pkg.
module ssvb_div (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               start,
    input  logic signed [ssvb_pkg::QUO_W-1:0]  dividend,
    input  logic        [ssvb_pkg::STEP_W-1:0] divisor,
    output logic                               done,
    output logic signed [ssvb_pkg::QUO_W-1:0]  quotient
);
    import ssvb_pkg::*;

    localparam int CNT_W = $clog2(MAG_W);

    div_state_t               state_reg, state_next;
    logic [MAG_W-1:0]         num_reg, num_next;
    logic [STEP_W-1:0]        rem_reg, rem_next;
    logic [CNT_W-1:0]         cnt_reg, cnt_next;
    logic                     neg_reg, neg_next;
    logic signed [QUO_W-1:0]  quot_reg, quot_next;

    logic [STEP_W:0]          trial;
    logic [STEP_W:0]          diff;
    logic                     ge;
    logic [MAG_W-1:0]         mag;

    // shift-subtract step
    assign trial = {rem_reg, num_reg[MAG_W-1]};
    assign ge    = trial >= {1'b0, divisor};
    assign diff  = trial - {1'b0, divisor};
    assign mag   = dividend[QUO_W-1] ? MAG_W'(-dividend) : MAG_W'(dividend);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            DIV_IDLE: if (start) state_next = DIV_RUN;
            DIV_RUN:  if (cnt_reg == CNT_W'(MAG_W - 1)) state_next = DIV_SIGN;
            DIV_SIGN: state_next = DIV_DONE;
            DIV_DONE: state_next = DIV_IDLE;
            default:  state_next = DIV_IDLE;
        endcase
    end

    always_comb
    begin
        done = (state_reg == DIV_DONE);
    end

    always_comb
    begin
        num_next  = num_reg;
        rem_next  = rem_reg;
        cnt_next  = cnt_reg;
        neg_next  = neg_reg;
        quot_next = quot_reg;
        case (state_reg)
            DIV_IDLE:
            begin
                if (start)
                begin
                    num_next = mag;
                    neg_next = dividend[QUO_W-1];
                    rem_next = '0;
                    cnt_next = '0;
                end
            end
            DIV_RUN:
            begin
                rem_next = ge ? diff[STEP_W-1:0] : trial[STEP_W-1:0];
                num_next = {num_reg[MAG_W-2:0], ge};
                cnt_next = cnt_reg + CNT_W'(1);
            end
            DIV_SIGN:
            begin
                quot_next = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= DIV_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg  <= num_next;
        rem_reg  <= rem_next;
        cnt_reg  <= cnt_next;
        neg_reg  <= neg_next;
        quot_reg <= quot_next;
    end

    assign quotient = quot_reg;

endmodule
